// ----- design/rle_nibble_unpacker_defines.svh -----
// ----------------------------------------------------------------------------
// rle_nibble_unpacker_defines.svh
// Assertion macros for the run-length nibble unpacker.
// ----------------------------------------------------------------------------
`ifndef RLE_NIBBLE_UNPACKER_DEFINES_SVH
`define RLE_NIBBLE_UNPACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define RNU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rnu assertion failed");
`define RNU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rnu sequencing assertion failed");
`else
`define RNU_ASSERT(lbl, prop)
`define RNU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/rnu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnu_pkg
// Shared types and constants of the run-length nibble unpacker.
// ----------------------------------------------------------------------------
package rnu_pkg;

  localparam int unsigned CW_W = 13;

  localparam int unsigned CELLS_PER_RESULT = 8;

  localparam logic [7:0] LIT_BASE = 8'h80;
  localparam logic [7:0] LIT_BIAS = 8'h7F;
  localparam logic [7:0] RUN_MAX  = 8'd128;
  localparam logic [3:0] NIB_MASK = 4'hF;

  localparam logic [CW_W-1:0] FRAME_CELLS_RST = 13'd880;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  typedef enum logic [2:0] {
    PH_TOKEN = 3'b001,
    PH_RUN   = 3'b010,
    PH_LIT   = 3'b100
  } phase_e;

  typedef struct packed {
    logic ended;
    logic dropped;
    logic fin;
  } chunk_flags_t;

endpackage

// ----- design/rnu_chunk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnu_chunk
// Shared chunk unit: sizes the next result against the cells left in the
// byte or run and the room left in the frame, and packs its nibbles.
// ----------------------------------------------------------------------------
module rnu_chunk #(
  parameter int unsigned MAX_FRAME_CELLS = 4096
) (
  input  logic [rnu_pkg::CW_W-1:0]                       frame_cells_i,
  input  logic [rnu_pkg::CW_W-1:0]                       cells_written_i,
  input  logic [8:0]                                     rem_i,
  input  logic                                           par_i,
  input  logic [7:0]                                     byte_i,
  output logic [$clog2(rnu_pkg::CELLS_PER_RESULT+1)-1:0] cnt_o,
  output logic [rnu_pkg::CELLS_PER_RESULT*4-1:0]         word_o,
  output logic [rnu_pkg::CW_W-1:0]                       cw_next_o,
  output rnu_pkg::chunk_flags_t                          flags_o
);
  import rnu_pkg::*;

  localparam int unsigned LimW = $clog2(MAX_FRAME_CELLS + 1);
  localparam int unsigned CmpW = (LimW > CW_W) ? LimW : CW_W;
  localparam int unsigned CntW = $clog2(CELLS_PER_RESULT + 1);

  logic [CmpW-1:0] frame_ext;
  logic [CmpW-1:0] lim;
  logic [CmpW-1:0] cw_ext;
  logic [CmpW-1:0] room;
  logic [8:0]      c1;
  logic [CmpW-1:0] c2;
  logic [3:0]      hi_nib;
  logic [3:0]      lo_nib;
  logic            odd;

  assign frame_ext = CmpW'(frame_cells_i);
  assign cw_ext    = CmpW'(cells_written_i);
  assign hi_nib    = byte_i[7:4];
  assign lo_nib    = byte_i[3:0] & NIB_MASK;

  always_comb begin
    if (frame_ext == '0) begin
      lim = CmpW'(1);
    end else if (frame_ext > CmpW'(MAX_FRAME_CELLS)) begin
      lim = CmpW'(MAX_FRAME_CELLS);
    end else begin
      lim = frame_ext;
    end
    room = (cw_ext >= lim) ? CmpW'(1) : (lim - cw_ext);
    c1   = (rem_i < 9'(CELLS_PER_RESULT)) ? rem_i : 9'(CELLS_PER_RESULT);
    c2   = (room < CmpW'(c1)) ? room : CmpW'(c1);
  end

  assign cnt_o           = c2[CntW-1:0];
  assign flags_o.ended   = (room == c2);
  assign flags_o.dropped = (room == c2) && (CmpW'(rem_i) != c2);
  assign flags_o.fin     = (room == c2) || (CmpW'(rem_i) == c2);
  assign cw_next_o       = (room == c2) ? '0 : (cells_written_i + CW_W'(c2[CntW-1:0]));

  always_comb begin
    odd    = 1'b0;
    word_o = '0;
    for (int j = 0; j < CELLS_PER_RESULT; j++) begin
      odd = par_i ^ 1'(j % 2);
      if (CntW'(j) < c2[CntW-1:0]) begin
        word_o[j*4 +: 4] = odd ? lo_nib : hi_nib;
      end
    end
  end

endmodule

// ----- design/rnu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnu_ctrl
// Sequencer: decodes tokens, holds the run or literal state and steps the
// chunk unit once per result until the byte, run or frame is used up.
// ----------------------------------------------------------------------------
module rnu_ctrl #(
  parameter int unsigned MAX_FRAME_CELLS = 4096
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           in_valid_i,
  input  logic [7:0]                                     source_byte_i,
  input  logic [rnu_pkg::CW_W-1:0]                       frame_cells_i,
  input  logic                                           adv_i,
  output logic                                           busy_o,
  output logic                                           res_valid_o,
  output logic [$clog2(rnu_pkg::CELLS_PER_RESULT+1)-1:0] cnt_o,
  output logic [rnu_pkg::CELLS_PER_RESULT*4-1:0]         word_o,
  output rnu_pkg::chunk_flags_t                          flags_o
);
  import rnu_pkg::*;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      pending_q, pending_d;
  logic [7:0]      byte_q, byte_d;
  logic [8:0]      rem_q, rem_d;
  logic [CW_W-1:0] cw_q, cw_d;
  logic            par_q, par_d;
  logic [CW_W-1:0] cw_next;
  logic [7:0]      reps;
  logic [7:0]      pend_dec;
  logic            accept;
  logic            step;

  rnu_chunk #(
    .MAX_FRAME_CELLS(MAX_FRAME_CELLS)
  ) u_chunk (
    .frame_cells_i  (frame_cells_i),
    .cells_written_i(cw_q),
    .rem_i          (rem_q),
    .par_i          (par_q),
    .byte_i         (byte_q),
    .cnt_o          (cnt_o),
    .word_o         (word_o),
    .cw_next_o      (cw_next),
    .flags_o        (flags_o)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);
  assign step        = res_valid_o && adv_i;
  assign reps        = (pending_q > RUN_MAX) ? RUN_MAX : pending_q;
  assign pend_dec    = (pending_q != '0) ? (pending_q - 8'd1) : '0;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    pending_d = pending_q;
    byte_d    = byte_q;
    rem_d     = rem_q;
    cw_d      = cw_q;
    par_d     = par_q;
    if (accept) begin
      byte_d = source_byte_i;
      par_d  = 1'b0;
      case (phase_q)
        PH_RUN: begin
          rem_d     = {reps, 1'b0};
          phase_d   = PH_TOKEN;
          pending_d = '0;
          state_d   = ST_EMIT;
        end
        PH_LIT: begin
          rem_d     = 9'd2;
          pending_d = pend_dec;
          if (pend_dec == '0) begin
            phase_d = PH_TOKEN;
          end
          state_d = ST_EMIT;
        end
        default: begin
          if (source_byte_i < LIT_BASE) begin
            pending_d = source_byte_i + 8'd1;
            phase_d   = PH_RUN;
          end else begin
            pending_d = source_byte_i - LIT_BIAS;
            phase_d   = PH_LIT;
          end
        end
      endcase
    end else if (step) begin
      cw_d  = cw_next;
      rem_d = rem_q - 9'(cnt_o);
      par_d = par_q ^ cnt_o[0];
      if (flags_o.ended) begin
        phase_d   = PH_TOKEN;
        pending_d = '0;
      end
      if (flags_o.fin) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_TOKEN;
      pending_q <= '0;
      cw_q      <= '0;
      rem_q     <= '0;
      par_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      pending_q <= pending_d;
      cw_q      <= cw_d;
      rem_q     <= rem_d;
      par_q     <= par_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// ----- design/rle_nibble_unpacker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_nibble_unpacker
// Run-length decoder that splits each decoded byte into two 4-bit cells and
// packs them into results, closing a frame after a set number of cells.
// ----------------------------------------------------------------------------
// A token byte is taken and gives no result.
// A run or literal byte is taken into the state registers; its first result
// is then registered at the output, followed by one result per unstalled
// cycle, ceil(kept / 8) in all. The input stays stalled until the last
// result is registered.
// After reset the frame size is 880 cells and the decoder waits for a token.
module rle_nibble_unpacker #(
  parameter int unsigned MAX_FRAME_CELLS = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               source_byte_i,
  input  logic                     cfg_we_i,
  input  logic [rnu_pkg::CW_W-1:0] cfg_wdata_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [31:0]              cells_o,
  output logic [3:0]               cell_count_o,
  output logic                     frame_end_o,
  output logic                     overrun_o,
  output logic                     last_o
);
  import rnu_pkg::*;

  `include "rle_nibble_unpacker_defines.svh"

  localparam int unsigned CntW = $clog2(CELLS_PER_RESULT + 1);

  logic [CW_W-1:0]               frame_cells_q;
  logic                          out_valid_q, out_valid_d;
  logic [31:0]                   cells_q;
  logic [3:0]                    count_q;
  logic                          frame_end_q;
  logic                          overrun_q;
  logic                          last_q;
  logic                          adv;
  logic                          res_valid;
  logic [CntW-1:0]               res_cnt;
  logic [CELLS_PER_RESULT*4-1:0] res_word;
  chunk_flags_t                  res_flags;
  logic [63:0]                   word_ext;
  logic [7:0]                    cnt_ext;

  assign adv = !out_valid_q || !out_stall_i;

  rnu_ctrl #(
    .MAX_FRAME_CELLS(MAX_FRAME_CELLS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .source_byte_i(source_byte_i),
    .frame_cells_i(frame_cells_q),
    .adv_i        (adv),
    .busy_o       (in_stall_o),
    .res_valid_o  (res_valid),
    .cnt_o        (res_cnt),
    .word_o       (res_word),
    .flags_o      (res_flags)
  );

  assign word_ext    = 64'(res_word);
  assign cnt_ext     = 8'(res_cnt);
  assign out_valid_d = adv ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cells_q <= FRAME_CELLS_RST;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_cells_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      cells_q     <= word_ext[31:0];
      count_q     <= cnt_ext[3:0];
      frame_end_q <= res_flags.ended;
      overrun_q   <= res_flags.dropped;
      last_q      <= res_flags.fin;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cells_o      = cells_q;
  assign cell_count_o = count_q;
  assign frame_end_o  = frame_end_q;
  assign overrun_o    = overrun_q;
  assign last_o       = last_q;

  `RNU_ASSERT(a_overrun_ends_frame, out_valid_o && overrun_o |-> frame_end_o && last_o)
  `RNU_ASSERT(a_frame_end_is_last, out_valid_o && frame_end_o |-> last_o)
  `RNU_ASSERT(a_busy_while_emitting, res_valid |-> in_stall_o)
  `RNU_ASSERT_NEXT(a_results_back_to_back, out_valid_o && !out_stall_i && !last_o, out_valid_o)

endmodule
